// ===== rtl/core/sltd_pkg.sv =====
// Shared types and constants of the slot limited task dispatcher.
// Depends on nothing; every RTL file of the block refers to it by scoped names.
package sltd_pkg;

   // Sizes of the storage.
   localparam int QUEUE_DEPTH  = 32;
   localparam int MAX_MACHINES = 64;
   localparam int MAX_SLOTS    = 16;

   // Queue index and fill count widths.
   localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // Machine table index and active counter widths.
   localparam int MIDX_W = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);

   // Field widths of the channels and registers.
   localparam int TAG_W    = 16;
   localparam int MACH_W   = 8;
   localparam int KIND_W   = 2;
   localparam int NUMM_W   = 7;
   localparam int SLOTS_W  = 5;
   localparam int CSR_W    = 7;
   localparam int REQ_DW   = 32;
   localparam int RSP_DW   = 24;

   // Request actions.
   typedef enum logic [1:0] {
      ACT_ADD    = 2'd0,
      ACT_PASS   = 2'd1,
      ACT_FINISH = 2'd2
   } action_type;

   // Task kinds that occupy a slot.
   typedef enum logic [KIND_W-1:0] {
      KIND_MAP    = 2'd0,
      KIND_REDUCE = 2'd1
   } kind_type;

   // Result events.
   typedef enum logic [2:0] {
      EV_ACCEPTED  = 3'd0,
      EV_FULL      = 3'd1,
      EV_STARTED   = 3'd2,
      EV_DROPPED   = 3'd3,
      EV_FIN_BAD   = 3'd4,
      EV_FIN_UNDER = 3'd5,
      EV_DONE      = 3'd6
   } event_type;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_NUM_MACHINES = 1'b0,
      CSR_SLOTS        = 1'b1
   } csr_index_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIN_CHK,
      ST_ENT_RD,
      ST_ENT_DEC,
      ST_DONE
   } state_type;

   // One pending queue entry.
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [MACH_W-1:0] mach;
      logic [TAG_W-1:0]  tag;
   } entry_type;

   // Active counts of one machine.
   typedef struct packed {
      logic [CNT_W-1:0] red_cnt;
      logic [CNT_W-1:0] map_cnt;
   } slot_row_type;

   // Control from the sequencer to the slot table.
   typedef struct packed {
      logic              rd_en;
      logic [MIDX_W-1:0] rd_addr;
      logic              upd_en;
      logic              upd_dec;
      logic              upd_reduce;
   } slot_ctl_type;

endpackage

// ===== rtl/core/sltd_queue.sv =====
// Pending task queue storage: one write port and one registered read port.
// Depends on sltd_pkg for the entry type and the queue depth.
module sltd_queue (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [sltd_pkg::QIDX_W-1:0]  wr_addr,
   input  sltd_pkg::entry_type          wr_data,
   input  logic                         rd_en,
   input  logic [sltd_pkg::QIDX_W-1:0]  rd_addr,
   output sltd_pkg::entry_type          rd_data
);

   sltd_pkg::entry_type mem [sltd_pkg::QUEUE_DEPTH];
   sltd_pkg::entry_type rd_data_ff;

   // Entries hold no reset value; only entries below the fill count are read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/sltd_slot_table.sv =====
// Per-machine active map and reduce counters with the shared increment and decrement unit.
// Depends on sltd_pkg for the row and control types and the table size.
module sltd_slot_table (
   input  logic                    clock,
   input  logic                    reset,
   input  sltd_pkg::slot_ctl_type  ctl,
   output sltd_pkg::slot_row_type  row
);

   sltd_pkg::slot_row_type            mem [sltd_pkg::MAX_MACHINES];
   logic [sltd_pkg::MAX_MACHINES-1:0] valid_ff;
   sltd_pkg::slot_row_type            rd_row_ff;
   logic [sltd_pkg::MIDX_W-1:0]       rd_addr_ff;
   logic                              rd_valid_ff;
   sltd_pkg::slot_row_type            wr_row;
   logic [sltd_pkg::CNT_W-1:0]        sel_cnt;
   logic [sltd_pkg::CNT_W-1:0]        sel_new;

   // A row never written since reset reads as all zero.
   assign row = rd_valid_ff ? rd_row_ff : '0;

   // One counter of the last row read moves up or down by one.
   always_comb begin
      sel_cnt = ctl.upd_reduce ? row.red_cnt : row.map_cnt;
      sel_new = ctl.upd_dec ? (sel_cnt - 1'b1) : (sel_cnt + 1'b1);
      wr_row  = row;
      if (ctl.upd_reduce) begin
         wr_row.red_cnt = sel_new;
      end else begin
         wr_row.map_cnt = sel_new;
      end
   end

   // Counter storage; an update writes back to the row that was last read.
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_row_ff  <= mem[ctl.rd_addr];
         rd_addr_ff <= ctl.rd_addr;
      end
      if (ctl.upd_en) begin
         mem[rd_addr_ff] <= wr_row;
      end
   end

   // Row valid bits stand in for clearing the counters at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (ctl.upd_en) begin
            valid_ff[rd_addr_ff] <= 1'b1;
         end
         if (ctl.rd_en) begin
            rd_valid_ff <= valid_ff[ctl.rd_addr];
         end
      end
   end

endmodule

// ===== rtl/core/slot_limited_task_dispatcher.sv =====
// Top level of the slot limited task dispatcher: request sequencer and result register.
// Depends on sltd_pkg, sltd_queue and sltd_slot_table.
//
//   Port group  Direction  Carries
//   req_*       in         tuser: action; tdata: task_tag, machine, task_kind
//   rsp_*       out        tuser: event_res; tdata: result_tag, result_machine; tlast: last
//   csr_*       in         register writes: num_machines, slots_per_machine
//
// A dispatch pass visits each queued entry in two states: ST_ENT_RD, where the
// queue read reaches the counter table read port, and ST_ENT_DEC, for the compare
// and counter update. A finish first passes through ST_FIN_CHK for its counter check.
// Reset is synchronous; counters clear at once through row valid bits.
// A stalled result holds the sequencer in the state that produced it.
module slot_limited_task_dispatcher (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [sltd_pkg::REQ_DW-1:0]    req_tdata,  // task_tag[15:0], machine[23:16], task_kind[25:24]
   input  logic [1:0]                     req_tuser,  // action[1:0]
   // Result channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [sltd_pkg::RSP_DW-1:0]    rsp_tdata,  // result_tag[15:0], result_machine[23:16]
   output logic [2:0]                     rsp_tuser,  // event_res[2:0]
   output logic                           rsp_tlast,
   // Configuration write port
   input  logic                           csr_we,
   input  logic [0:0]                     csr_index,
   input  logic [sltd_pkg::CSR_W-1:0]     csr_wdata
);

   sltd_pkg::state_type            state_ff, state_in;
   logic [sltd_pkg::QCNT_W-1:0]    pending_count_ff, pending_count_in;
   logic [sltd_pkg::QIDX_W-1:0]    idx_ff, idx_in;
   logic [sltd_pkg::QCNT_W-1:0]    keep_ff, keep_in;
   logic [sltd_pkg::MACH_W-1:0]    fin_mach_ff, fin_mach_in;
   logic [sltd_pkg::KIND_W-1:0]    fin_kind_ff, fin_kind_in;
   logic [sltd_pkg::NUMM_W-1:0]    num_machines_ff;
   logic [sltd_pkg::SLOTS_W-1:0]   slots_ff;

   logic                           rsp_valid_ff, rsp_valid_in;
   sltd_pkg::event_type            rsp_ev_ff, rsp_ev_in;
   logic [sltd_pkg::TAG_W-1:0]     rsp_tag_ff, rsp_tag_in;
   logic [sltd_pkg::MACH_W-1:0]    rsp_mach_ff, rsp_mach_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic                           out_free;
   logic                           emit_en;
   sltd_pkg::event_type            emit_ev;
   logic [sltd_pkg::TAG_W-1:0]     emit_tag;
   logic [sltd_pkg::MACH_W-1:0]    emit_mach;
   logic                           emit_last;

   sltd_pkg::entry_type            req_entry;
   logic [1:0]                     req_action;
   logic                           req_go;

   logic                           q_wr_en;
   logic [sltd_pkg::QIDX_W-1:0]    q_wr_addr;
   sltd_pkg::entry_type            q_wr_data;
   logic                           q_rd_en;
   logic [sltd_pkg::QIDX_W-1:0]    q_rd_addr;
   sltd_pkg::entry_type            q_rd_data;

   sltd_pkg::slot_ctl_type         slot_ctl;
   sltd_pkg::slot_row_type         slot_row;

   logic [7:0]                     slot_lim;
   logic                           ent_ok;
   logic                           ent_start;
   logic                           ent_last;
   logic                           fin_ok;

   // A machine id is valid below both the configured count and the table size.
   function automatic logic mach_valid(input logic [sltd_pkg::MACH_W-1:0] mach,
                                       input logic [sltd_pkg::NUMM_W-1:0] num);
      logic [8:0] m9;
      m9 = {1'b0, mach};
      return (m9 < {2'b00, num}) && (m9 < 9'(sltd_pkg::MAX_MACHINES));
   endfunction

   // A counter may grow only while below the slot limit.
   function automatic logic below_lim(input logic [sltd_pkg::CNT_W-1:0] cnt,
                                      input logic [7:0] lim);
      return 8'(cnt) < lim;
   endfunction

   sltd_queue u_queue (
      .clock   (clock),
      .wr_en   (q_wr_en),
      .wr_addr (q_wr_addr),
      .wr_data (q_wr_data),
      .rd_en   (q_rd_en),
      .rd_addr (q_rd_addr),
      .rd_data (q_rd_data)
   );

   sltd_slot_table u_slot_table (
      .clock (clock),
      .reset (reset),
      .ctl   (slot_ctl),
      .row   (slot_row)
   );

   // Request fields.
   assign req_entry.tag  = req_tdata[15:0];
   assign req_entry.mach = req_tdata[23:16];
   assign req_entry.kind = req_tdata[25:24];
   assign req_action     = req_tuser;

   // Result channel drive.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ev_ff;
   assign rsp_tdata  = {rsp_mach_ff, rsp_tag_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == sltd_pkg::ST_IDLE) && out_free;
   assign req_go     = req_tvalid && req_tready;

   // Effective slot limit, the checks on the current entry and the machine check of a finish.
   always_comb begin
      slot_lim = (8'(slots_ff) > 8'(sltd_pkg::MAX_SLOTS)) ? 8'(sltd_pkg::MAX_SLOTS)
                                                          : 8'(slots_ff);
      ent_ok    = mach_valid(q_rd_data.mach, num_machines_ff);
      ent_start = ent_ok &&
                  (((q_rd_data.kind == sltd_pkg::KIND_MAP) &&
                    below_lim(slot_row.map_cnt, slot_lim)) ||
                   ((q_rd_data.kind == sltd_pkg::KIND_REDUCE) &&
                    below_lim(slot_row.red_cnt, slot_lim)));
      ent_last  = ((sltd_pkg::QCNT_W)'(idx_ff) + 1'b1) == pending_count_ff;
      fin_ok    = mach_valid(req_entry.mach, num_machines_ff);
   end

   // Sequencer: next state, memory controls and the result to emit.
   always_comb begin
      state_in         = state_ff;
      pending_count_in = pending_count_ff;
      idx_in           = idx_ff;
      keep_in          = keep_ff;
      fin_mach_in      = fin_mach_ff;
      fin_kind_in      = fin_kind_ff;

      q_wr_en   = 1'b0;
      q_wr_addr = pending_count_ff[sltd_pkg::QIDX_W-1:0];
      q_wr_data = req_entry;
      q_rd_en   = 1'b0;
      q_rd_addr = '0;

      slot_ctl.rd_en      = 1'b0;
      slot_ctl.rd_addr    = req_entry.mach[sltd_pkg::MIDX_W-1:0];
      slot_ctl.upd_en     = 1'b0;
      slot_ctl.upd_dec    = 1'b0;
      slot_ctl.upd_reduce = 1'b0;

      emit_en   = 1'b0;
      emit_ev   = sltd_pkg::EV_DONE;
      emit_tag  = '0;
      emit_mach = '0;
      emit_last = 1'b0;

      unique case (state_ff)
         sltd_pkg::ST_IDLE: begin
            if (req_go) begin
               unique case (req_action)
                  sltd_pkg::ACT_ADD: begin
                     emit_en   = 1'b1;
                     emit_tag  = req_entry.tag;
                     emit_mach = req_entry.mach;
                     emit_last = 1'b1;
                     if (pending_count_ff >= (sltd_pkg::QCNT_W)'(sltd_pkg::QUEUE_DEPTH)) begin
                        emit_ev = sltd_pkg::EV_FULL;
                     end else begin
                        emit_ev          = sltd_pkg::EV_ACCEPTED;
                        q_wr_en          = 1'b1;
                        pending_count_in = pending_count_ff + 1'b1;
                     end
                  end
                  sltd_pkg::ACT_PASS: begin
                     idx_in  = '0;
                     keep_in = '0;
                     if (pending_count_ff == '0) begin
                        state_in = sltd_pkg::ST_DONE;
                     end else begin
                        q_rd_en  = 1'b1;
                        state_in = sltd_pkg::ST_ENT_RD;
                     end
                  end
                  sltd_pkg::ACT_FINISH: begin
                     if (!fin_ok) begin
                        emit_en   = 1'b1;
                        emit_ev   = sltd_pkg::EV_FIN_BAD;
                        emit_mach = req_entry.mach;
                        emit_last = 1'b1;
                     end else begin
                        slot_ctl.rd_en = 1'b1;
                        fin_mach_in    = req_entry.mach;
                        fin_kind_in    = req_entry.kind;
                        state_in       = sltd_pkg::ST_FIN_CHK;
                     end
                  end
                  default: begin
                     // The spare action code is dropped without a result.
                  end
               endcase
            end
         end

         sltd_pkg::ST_FIN_CHK: begin
            // Finished task: report an underflow, or else release a map or reduce slot and run a pass.
            if (((fin_kind_ff == sltd_pkg::KIND_MAP) && (slot_row.map_cnt == '0)) ||
                ((fin_kind_ff == sltd_pkg::KIND_REDUCE) && (slot_row.red_cnt == '0))) begin
               if (out_free) begin
                  emit_en   = 1'b1;
                  emit_ev   = sltd_pkg::EV_FIN_UNDER;
                  emit_mach = fin_mach_ff;
                  emit_last = 1'b1;
                  state_in  = sltd_pkg::ST_IDLE;
               end
            end else begin
               slot_ctl.upd_en     = (fin_kind_ff == sltd_pkg::KIND_MAP) ||
                                     (fin_kind_ff == sltd_pkg::KIND_REDUCE);
               slot_ctl.upd_dec    = 1'b1;
               slot_ctl.upd_reduce = (fin_kind_ff == sltd_pkg::KIND_REDUCE);
               idx_in              = '0;
               keep_in             = '0;
               if (pending_count_ff == '0) begin
                  state_in = sltd_pkg::ST_DONE;
               end else begin
                  q_rd_en  = 1'b1;
                  state_in = sltd_pkg::ST_ENT_RD;
               end
            end
         end

         sltd_pkg::ST_ENT_RD: begin
            // The entry is out of the queue; fetch its machine's counters.
            slot_ctl.rd_en   = 1'b1;
            slot_ctl.rd_addr = q_rd_data.mach[sltd_pkg::MIDX_W-1:0];
            state_in         = sltd_pkg::ST_ENT_DEC;
         end

         sltd_pkg::ST_ENT_DEC: begin
            // Drop, start or keep the entry; kept entries move down to close gaps.
            if (ent_start || !ent_ok) begin
               emit_en   = out_free;
               emit_ev   = ent_ok ? sltd_pkg::EV_STARTED : sltd_pkg::EV_DROPPED;
               emit_tag  = q_rd_data.tag;
               emit_mach = q_rd_data.mach;
            end
            if (out_free || !(ent_start || !ent_ok)) begin
               if (ent_start) begin
                  slot_ctl.upd_en     = 1'b1;
                  slot_ctl.upd_reduce = (q_rd_data.kind == sltd_pkg::KIND_REDUCE);
               end else if (ent_ok) begin
                  q_wr_en   = 1'b1;
                  q_wr_addr = keep_ff[sltd_pkg::QIDX_W-1:0];
                  q_wr_data = q_rd_data;
                  keep_in   = keep_ff + 1'b1;
               end
               idx_in = idx_ff + 1'b1;
               if (ent_last) begin
                  state_in = sltd_pkg::ST_DONE;
               end else begin
                  q_rd_en   = 1'b1;
                  q_rd_addr = idx_ff + 1'b1;
                  state_in  = sltd_pkg::ST_ENT_RD;
               end
            end
         end

         sltd_pkg::ST_DONE: begin
            if (out_free) begin
               emit_en          = 1'b1;
               emit_ev          = sltd_pkg::EV_DONE;
               emit_last        = 1'b1;
               pending_count_in = keep_ff;
               state_in         = sltd_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = sltd_pkg::ST_IDLE;
         end
      endcase
   end

   // Result register: load on emit, clear once the transfer completes.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_ev_in    = rsp_ev_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_mach_in  = rsp_mach_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit_en) begin
         rsp_valid_in = 1'b1;
         rsp_ev_in    = emit_ev;
         rsp_tag_in   = emit_tag;
         rsp_mach_in  = emit_mach;
         rsp_last_in  = emit_last;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= sltd_pkg::ST_IDLE;
         pending_count_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         pending_count_ff <= pending_count_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Payload and scan registers.
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      keep_ff     <= keep_in;
      fin_mach_ff <= fin_mach_in;
      fin_kind_ff <= fin_kind_in;
      rsp_ev_ff   <= rsp_ev_in;
      rsp_tag_ff  <= rsp_tag_in;
      rsp_mach_ff <= rsp_mach_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         num_machines_ff <= (sltd_pkg::NUMM_W)'(1);
         slots_ff        <= (sltd_pkg::SLOTS_W)'(1);
      end else if (csr_we) begin
         unique case (sltd_pkg::csr_index_type'(csr_index))
            sltd_pkg::CSR_NUM_MACHINES: num_machines_ff <= csr_wdata;
            sltd_pkg::CSR_SLOTS:        slots_ff        <= csr_wdata[sltd_pkg::SLOTS_W-1:0];
         endcase
      end
   end

   // The fill count never passes the queue depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      pending_count_ff <= (sltd_pkg::QCNT_W)'(sltd_pkg::QUEUE_DEPTH))
      else $error("pending count above queue depth");

   // During a pass the compaction point trails the scan and the scan stays in the queue.
   a_scan_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sltd_pkg::ST_ENT_DEC) |->
         ((keep_ff <= (sltd_pkg::QCNT_W)'(idx_ff)) &&
          ((sltd_pkg::QCNT_W)'(idx_ff) < pending_count_ff)))
      else $error("pass scan out of order");

   // A started task is never the final result of a request.
   a_started_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == sltd_pkg::EV_STARTED)) |-> !rsp_tlast)
      else $error("started result marked last");

   // A counter only grows while below the slot limit.
   a_slot_limit: assert property (@(posedge clock) disable iff (reset)
      (slot_ctl.upd_en && !slot_ctl.upd_dec) |->
         below_lim(slot_ctl.upd_reduce ? slot_row.red_cnt : slot_row.map_cnt, slot_lim))
      else $error("slot counter raised at limit");

   // A finish only lowers a counter that is above zero.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      (slot_ctl.upd_en && slot_ctl.upd_dec) |->
         ((slot_ctl.upd_reduce ? slot_row.red_cnt : slot_row.map_cnt) != '0))
      else $error("slot counter lowered below zero");

endmodule

// ===== verif/slot_limited_task_dispatcher_tb.sv =====
// Self-checking testbench for the slot limited task dispatcher.
// Depends on sltd_pkg and slot_limited_task_dispatcher; drives a directed table, a queue
// overflow, then random traffic, and checks every result transfer against a local predictor.
module slot_limited_task_dispatcher_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sltd_pkg::*;

   // Codes that the package does not name.
   localparam logic [1:0] ACT_IGNORED = 2'd3;
   localparam logic [1:0] KIND_OTHER  = 2'd2;
   localparam logic [1:0] KIND_SPARE  = 2'd3;

   localparam int RESET_CYCLES = 4;
   localparam int SETTLE_CYCLES = 2 * QUEUE_DEPTH + 16;
   localparam int QUIET_LIMIT  = 3000;
   localparam int LONG_HOLD    = 400;
   localparam int HOLD_AT      = 10;
   localparam int PHASE_ITEMS  = 52;
   localparam int N_PHASES     = 8;
   localparam int MAX_REPORTS  = 100;

   // Register settings of the random phases, extremes and out-of-range values among them.
   localparam int PH_MACHINES [N_PHASES] = '{64, 4, 127, 2, 0, 9, 1, 64};
   localparam int PH_SLOTS    [N_PHASES] = '{16, 2, 31, 0, 5, 3, 16, 1};

   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [MACH_W-1:0] mach;
      logic [KIND_W-1:0] kind;
   } pending_task_type;

   typedef struct packed {
      event_type         ev;
      logic [TAG_W-1:0]  tag;
      logic [MACH_W-1:0] mach;
      logic              last;
   } dispatch_event_type;

   // One directed request; a pinned row carries its single expected result.
   typedef struct packed {
      logic [1:0]        act;
      logic [TAG_W-1:0]  tag;
      logic [MACH_W-1:0] mach;
      logic [KIND_W-1:0] kind;
      logic              pinned;
      event_type         ev;
      logic [TAG_W-1:0]  rtag;
      logic [MACH_W-1:0] rmach;
   } stim_row_type;

   localparam int N_DIRECTED = 20;
   localparam stim_row_type DIRECTED [N_DIRECTED] = '{
      '{ACT_PASS,    16'h0000, 8'h00, KIND_MAP,    1'b1, EV_DONE,      16'h0000, 8'h00},
      '{ACT_FINISH,  16'h0000, 8'h00, KIND_MAP,    1'b1, EV_FIN_UNDER, 16'h0000, 8'h00},
      '{ACT_FINISH,  16'hFFFF, 8'h00, KIND_REDUCE, 1'b1, EV_FIN_UNDER, 16'h0000, 8'h00},
      '{ACT_FINISH,  16'h0000, 8'hFF, KIND_SPARE,  1'b1, EV_FIN_BAD,   16'h0000, 8'hFF},
      '{ACT_FINISH,  16'h0000, 8'h01, KIND_MAP,    1'b1, EV_FIN_BAD,   16'h0000, 8'h01},
      '{ACT_ADD,     16'hFFFF, 8'h00, KIND_MAP,    1'b1, EV_ACCEPTED,  16'hFFFF, 8'h00},
      '{ACT_ADD,     16'h0000, 8'h00, KIND_MAP,    1'b1, EV_ACCEPTED,  16'h0000, 8'h00},
      '{ACT_ADD,     16'h1234, 8'h00, KIND_REDUCE, 1'b1, EV_ACCEPTED,  16'h1234, 8'h00},
      '{ACT_ADD,     16'hABCD, 8'hFF, KIND_SPARE,  1'b1, EV_ACCEPTED,  16'hABCD, 8'hFF},
      '{ACT_ADD,     16'h5555, 8'h00, KIND_OTHER,  1'b1, EV_ACCEPTED,  16'h5555, 8'h00},
      '{ACT_ADD,     16'hAAAA, 8'h01, KIND_REDUCE, 1'b1, EV_ACCEPTED,  16'hAAAA, 8'h01},
      '{ACT_IGNORED, 16'hFFFF, 8'hFF, KIND_SPARE,  1'b0, EV_ACCEPTED,  16'h0000, 8'h00},
      '{ACT_PASS,    16'h0F0F, 8'h80, KIND_MAP,    1'b0, EV_ACCEPTED,  16'h0000, 8'h00},
      '{ACT_FINISH,  16'h0000, 8'h00, KIND_MAP,    1'b0, EV_ACCEPTED,  16'h0000, 8'h00},
      '{ACT_FINISH,  16'h0000, 8'h00, KIND_OTHER,  1'b0, EV_ACCEPTED,  16'h0000, 8'h00},
      '{ACT_FINISH,  16'h0000, 8'h00, KIND_SPARE,  1'b0, EV_ACCEPTED,  16'h0000, 8'h00},
      '{ACT_FINISH,  16'h0000, 8'h00, KIND_REDUCE, 1'b0, EV_ACCEPTED,  16'h0000, 8'h00},
      '{ACT_FINISH,  16'h0000, 8'h00, KIND_REDUCE, 1'b1, EV_FIN_UNDER, 16'h0000, 8'h00},
      '{ACT_FINISH,  16'h0000, 8'h00, KIND_MAP,    1'b0, EV_ACCEPTED,  16'h0000, 8'h00},
      '{ACT_FINISH,  16'h0000, 8'h00, KIND_MAP,    1'b1, EV_FIN_UNDER, 16'h0000, 8'h00}
   };

   logic                clock = 1'b0;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [REQ_DW-1:0]   req_tdata;
   logic [1:0]          req_tuser;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RSP_DW-1:0]   rsp_tdata;
   logic [2:0]          rsp_tuser;
   logic                rsp_tlast;
   logic                csr_we;
   logic [0:0]          csr_index;
   logic [CSR_W-1:0]    csr_wdata;

   // Predictor state.
   pending_task_type    pending_tasks [$];
   logic [CNT_W-1:0]    map_busy    [MAX_MACHINES];
   logic [CNT_W-1:0]    reduce_busy [MAX_MACHINES];
   logic [NUMM_W-1:0]   cfg_machines;
   logic [SLOTS_W-1:0]  cfg_slots;
   dispatch_event_type  new_events [$];
   dispatch_event_type  expected_events [$];

   // Stimulus control shared between processes.
   bit                  idle_on;
   bit                  no_gap;
   bit                  long_hold_req;
   bit                  row_pinned;
   dispatch_event_type  row_pin_event;
   int                  sent_count;
   int                  mismatch_count;

   slot_limited_task_dispatcher u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("%0t mismatch: %s", $time, msg);
   endtask

   function automatic dispatch_event_type make_event(input event_type ev,
                                                     input logic [TAG_W-1:0] tag,
                                                     input logic [MACH_W-1:0] mach,
                                                     input logic last);
      dispatch_event_type r;
      r.ev = ev;
      r.tag = tag;
      r.mach = mach;
      r.last = last;
      return r;
   endfunction

   function automatic bit machine_valid(input logic [MACH_W-1:0] m);
      return (m < cfg_machines) && (m < MAX_MACHINES);
   endfunction

   task automatic clear_model();
      pending_tasks.delete();
      expected_events.delete();
      foreach (map_busy[m]) begin
         map_busy[m] = '0;
         reduce_busy[m] = '0;
      end
      cfg_machines = NUMM_W'(1);
      cfg_slots = SLOTS_W'(1);
   endtask

   // Walk the queue oldest first: drop bad machines, start tasks with a free slot,
   // keep the rest in order, and close with a done event.
   task automatic run_dispatch_pass();
      pending_task_type   kept [$];
      pending_task_type   e;
      logic [SLOTS_W-1:0] lim;
      logic [MIDX_W-1:0]  mi;
      lim = SLOTS_W'((cfg_slots > MAX_SLOTS) ? MAX_SLOTS : int'(cfg_slots));
      foreach (pending_tasks[i]) begin
         e = pending_tasks[i];
         mi = e.mach[MIDX_W-1:0];
         if (!machine_valid(e.mach)) begin
            new_events.push_back(make_event(EV_DROPPED, e.tag, e.mach, 1'b0));
         end else if (e.kind == KIND_MAP && map_busy[mi] < lim) begin
            map_busy[mi]++;
            new_events.push_back(make_event(EV_STARTED, e.tag, e.mach, 1'b0));
         end else if (e.kind == KIND_REDUCE && reduce_busy[mi] < lim) begin
            reduce_busy[mi]++;
            new_events.push_back(make_event(EV_STARTED, e.tag, e.mach, 1'b0));
         end else begin
            kept.push_back(e);
         end
      end
      pending_tasks = kept;
      new_events.push_back(make_event(EV_DONE, '0, '0, 1'b1));
   endtask

   // Predict the results of one accepted request into new_events.
   task automatic apply_request(input logic [1:0] act, input logic [TAG_W-1:0] tag,
                                input logic [MACH_W-1:0] mach, input logic [KIND_W-1:0] kind);
      pending_task_type  e;
      logic [MIDX_W-1:0] mi;
      mi = mach[MIDX_W-1:0];
      case (act)
         ACT_ADD: begin
            if (pending_tasks.size() >= QUEUE_DEPTH) begin
               new_events.push_back(make_event(EV_FULL, tag, mach, 1'b1));
            end else begin
               e.tag = tag;
               e.mach = mach;
               e.kind = kind;
               pending_tasks.push_back(e);
               new_events.push_back(make_event(EV_ACCEPTED, tag, mach, 1'b1));
            end
         end
         ACT_PASS: begin
            run_dispatch_pass();
         end
         ACT_FINISH: begin
            if (!machine_valid(mach)) begin
               new_events.push_back(make_event(EV_FIN_BAD, '0, mach, 1'b1));
            end else if ((kind == KIND_MAP && map_busy[mi] == '0) ||
                         (kind == KIND_REDUCE && reduce_busy[mi] == '0)) begin
               new_events.push_back(make_event(EV_FIN_UNDER, '0, mach, 1'b1));
            end else begin
               if (kind == KIND_MAP) map_busy[mi]--;
               else if (kind == KIND_REDUCE) reduce_busy[mi]--;
               run_dispatch_pass();
            end
         end
         default: begin
            // An ignored action leaves no trace.
         end
      endcase
   endtask

   task automatic check_result();
      dispatch_event_type want;
      dispatch_event_type got;
      got.ev = event_type'(rsp_tuser);
      got.tag = rsp_tdata[TAG_W-1:0];
      got.mach = rsp_tdata[TAG_W+MACH_W-1:TAG_W];
      got.last = rsp_tlast;
      if (expected_events.size() == 0) begin
         report_mismatch($sformatf("unexpected result event %0d tag %h machine %0d",
                                   got.ev, got.tag, got.mach));
         return;
      end
      want = expected_events.pop_front();
      if (got.ev !== want.ev)
         report_mismatch($sformatf("event %0d, expected %0d", got.ev, want.ev));
      if (got.tag !== want.tag)
         report_mismatch($sformatf("tag %h, expected %h", got.tag, want.tag));
      if (got.mach !== want.mach)
         report_mismatch($sformatf("machine %0d, expected %0d", got.mach, want.mach));
      if (got.last !== want.last)
         report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
   endtask

   // All transfers and register writes are observed at the rising edge.
   always @(posedge clock) begin
      if (reset) begin
         clear_model();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_NUM_MACHINES) cfg_machines = csr_wdata[NUMM_W-1:0];
            else if (csr_index == CSR_SLOTS) cfg_slots = csr_wdata[SLOTS_W-1:0];
         end
         if (req_tvalid && req_tready) begin
            new_events.delete();
            apply_request(req_tuser, req_tdata[TAG_W-1:0], req_tdata[TAG_W+MACH_W-1:TAG_W],
                          req_tdata[TAG_W+MACH_W+KIND_W-1:TAG_W+MACH_W]);
            if (row_pinned) expected_events.push_back(row_pin_event);
            else foreach (new_events[i]) expected_events.push_back(new_events[i]);
         end
         if (rsp_tvalid && rsp_tready) check_result();
      end
   end

   // Result side: random stall bursts, plus one long hold when requested.
   initial begin : receiver
      int stall;
      stall = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            stall = LONG_HOLD;
            long_hold_req = 1'b0;
         end else if (stall == 0 && idle_on && $urandom_range(0, 9) == 0) begin
            stall = $urandom_range(1, 17);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Ends the run when no transfer of either channel happens for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("slot_limited_task_dispatcher verification failed");
      $finish;
   end

   // Offer one request from a falling edge and return at the falling edge after its transfer.
   task automatic send_req(input logic [1:0] act, input logic [TAG_W-1:0] tag,
                           input logic [MACH_W-1:0] mach, input logic [KIND_W-1:0] kind,
                           input logic pinned, input dispatch_event_type pin_event);
      int gap;
      gap = 0;
      if (idle_on && !no_gap && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 17);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      row_pinned = pinned;
      row_pin_event = pin_event;
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {{(REQ_DW-TAG_W-MACH_W-KIND_W){1'b0}}, kind, mach, tag};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Stop offering and wait until every predicted result has been taken.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (expected_events.size() != 0);
   endtask

   // Registers change only on an idle block, after an ignored request has had time to retire.
   task automatic write_config(input int machines, input int slots);
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_NUM_MACHINES;
      csr_wdata <= machines[CSR_W-1:0];
      @(negedge clock);
      csr_index <= CSR_SLOTS;
      csr_wdata <= slots[CSR_W-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Mostly adds on valid machines, passes and finishes of running tasks; some noise.
   task automatic random_request();
      int                pick;
      int                eff;
      int                n;
      int                m;
      logic [1:0]        act;
      logic [KIND_W-1:0] kind;
      logic [TAG_W-1:0]  tag;
      logic [MACH_W-1:0] mach;
      logic [MACH_W-1:0] busy_mach [$];
      logic [KIND_W-1:0] busy_kind [$];
      eff = (int'(cfg_machines) < MAX_MACHINES) ? int'(cfg_machines) : MAX_MACHINES;
      tag = TAG_W'($urandom());
      mach = MACH_W'((eff > 0 && $urandom_range(0, 99) < 85) ? $urandom_range(0, eff - 1)
                                                             : $urandom());
      kind = KIND_W'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 1)
                                                  : $urandom_range(2, 3));
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         act = ACT_ADD;
      end else if (pick < 65) begin
         act = ACT_PASS;
      end else if (pick < 96) begin
         act = ACT_FINISH;
         for (m = 0; m < MAX_MACHINES; m++) begin
            if (map_busy[m] != 0) begin
               busy_mach.push_back(MACH_W'(m));
               busy_kind.push_back(KIND_MAP);
            end
            if (reduce_busy[m] != 0) begin
               busy_mach.push_back(MACH_W'(m));
               busy_kind.push_back(KIND_REDUCE);
            end
         end
         if (busy_mach.size() > 0 && $urandom_range(0, 99) < 80) begin
            n = $urandom_range(0, busy_mach.size() - 1);
            mach = busy_mach[n];
            kind = busy_kind[n];
         end
      end else begin
         act = ACT_IGNORED;
      end
      if (act != ACT_IGNORED) sent_count++;
      send_req(act, tag, mach, kind, 1'b0, '0);
   endtask

   initial begin : stimulus
      int  k;
      int  ph;
      int  phase_start;
      bit  long_hold_done;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = ACT_ADD;
      csr_we = 1'b0;
      csr_index = CSR_NUM_MACHINES;
      csr_wdata = '0;
      idle_on = 1'b1;
      no_gap = 1'b0;
      long_hold_req = 1'b0;
      row_pinned = 1'b0;
      row_pin_event = '0;
      sent_count = 0;
      mismatch_count = 0;
      long_hold_done = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table under the reset register values.
      for (k = 0; k < N_DIRECTED; k++)
         send_req(DIRECTED[k].act, DIRECTED[k].tag, DIRECTED[k].mach, DIRECTED[k].kind,
                  DIRECTED[k].pinned,
                  make_event(DIRECTED[k].ev, DIRECTED[k].rtag, DIRECTED[k].rmach, 1'b1));

      // Fill the queue with tasks that never start, overflow it, then drop them all
      // in one pass by making every machine invalid.
      for (k = 0; k < QUEUE_DEPTH + 1; k++)
         send_req(ACT_ADD, TAG_W'($urandom()), 8'h00, (k % 2) ? KIND_OTHER : KIND_SPARE,
                  1'b0, '0);
      send_req(ACT_PASS, TAG_W'($urandom()), MACH_W'($urandom()), KIND_W'($urandom()),
               1'b0, '0);
      write_config(0, 1);
      send_req(ACT_PASS, TAG_W'($urandom()), MACH_W'($urandom()), KIND_W'($urandom()),
               1'b0, '0);

      // Random phases, one per register setting; the last one runs without idling.
      for (ph = 0; ph < N_PHASES; ph++) begin
         write_config(PH_MACHINES[ph], PH_SLOTS[ph]);
         idle_on = (ph != N_PHASES - 1);
         phase_start = sent_count;
         while (sent_count - phase_start < PHASE_ITEMS) begin
            if (ph == 0 && sent_count - phase_start == HOLD_AT && !long_hold_done) begin
               long_hold_req = 1'b1;
               long_hold_done = 1'b1;
               no_gap = 1'b1;
            end
            if (sent_count - phase_start >= HOLD_AT + 40) no_gap = 1'b0;
            if (idle_on && $urandom_range(0, 49) == 0) drain_results();
            random_request();
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("slot_limited_task_dispatcher verification clean");
      end else begin
         $display("slot_limited_task_dispatcher verification failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/sltd_pkg.sv
rtl/core/sltd_queue.sv
rtl/core/sltd_slot_table.sv
rtl/core/slot_limited_task_dispatcher.sv
verif/slot_limited_task_dispatcher_tb.sv
